[sv/irt_pkg.sv]
// Shared types and codes for the inode reference-count table.
package irt_pkg;

  // Request codes
  localparam logic [1:0] OP_GET     = 2'd0;
  localparam logic [1:0] OP_GET_REF = 2'd1;
  localparam logic [1:0] OP_UNLINK  = 2'd2;
  localparam logic [1:0] OP_RELEASE = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_UNDER = 2'd2;
  localparam logic [1:0] ST_OVER  = 2'd3;

  localparam int KEY_W = 64;
  localparam int CNT_W = 32;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // One stored table entry
  typedef struct packed {
    logic             valid;
    logic             unlinked;
    logic [CNT_W-1:0] count;
    logic [KEY_W-1:0] key;
  } entry_t;

  // Outcome of the key scan
  typedef struct packed {
    logic done;
    logic hit;
    logic free_found;
  } scan_res_t;

endpackage

[sv/irt_ram.sv]
// Single-port-write, single-port-read entry store with registered read data.
module irt_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  irt_pkg::entry_t  wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output irt_pkg::entry_t  rdata
);

  irt_pkg::entry_t mem [DEPTH];
  irt_pkg::entry_t rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/irt_match.sv]
// Shared key comparator: walks entries one per cycle, tracks hit and first free slot.
module irt_match #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        vld,
  input  logic [AW-1:0]               idx,
  input  irt_pkg::entry_t             data,
  input  logic [irt_pkg::KEY_W-1:0]   key,
  output irt_pkg::scan_res_t          res,
  output logic [AW-1:0]               hit_idx,
  output logic [AW-1:0]               free_idx,
  output irt_pkg::entry_t             hit_ent
);

  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic            done_r;
  logic            hit_r;
  logic            free_r;
  logic [AW-1:0]   hit_idx_r;
  logic [AW-1:0]   free_idx_r;
  irt_pkg::entry_t hit_ent_r;
  logic            key_eq;

  // One compare per cycle
  assign key_eq = data.valid && (data.key == key);

  // Track scan outcome; freeze once done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
      hit_r  <= 1'b0;
      free_r <= 1'b0;
    end else if (start) begin
      done_r <= 1'b0;
      hit_r  <= 1'b0;
      free_r <= 1'b0;
    end else if (vld && !done_r) begin
      if (key_eq) begin
        hit_r     <= 1'b1;
        done_r    <= 1'b1;
        hit_idx_r <= idx;
        hit_ent_r <= data;
      end else begin
        if (!data.valid && !free_r) begin
          free_r     <= 1'b1;
          free_idx_r <= idx;
        end
        if (idx == LAST) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign res.done       = done_r;
  assign res.hit        = hit_r;
  assign res.free_found = free_r;
  assign hit_idx        = hit_idx_r;
  assign free_idx       = free_idx_r;
  assign hit_ent        = hit_ent_r;

endmodule

[sv/inode_refcount_table_unit.sv]
// Top level: request sequencer, update logic and result register of the refcount table.
//
//  channel | ports                                            | direction
//  --------+--------------------------------------------------+----------
//  in      | in_valid, in_ready, in_operation, in_inode_number,|
//          | in_release_count                                 | in
//  out     | out_valid, out_ready, out_status,                |
//          | out_answer_flag, out_count_after                 | out
//
//  An item passes through an accept step, a key scan (one entry compared per
//  cycle through the shared comparator, ending early on a hit) and an update
//  step. After reset a clearing pass empties the table before the first item is
//  taken. The update waits while a previous result is still held in the output
//  register.
module inode_refcount_table_unit #(
  parameter int ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [63:0] in_inode_number,
  input  logic [31:0] in_release_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_answer_flag,
  output logic [31:0] out_count_after
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_SCAN, S_EXEC} state_t;

  state_t                      state_r;
  logic [AW-1:0]               issue_idx_r;
  logic                        issue_on_r;
  logic                        cmp_vld_r;
  logic [AW-1:0]               cmp_idx_r;
  logic [1:0]                  op_r;
  logic [irt_pkg::KEY_W-1:0]   key_r;
  logic [irt_pkg::CNT_W-1:0]   rel_r;
  logic                        out_valid_r;
  logic [1:0]                  status_r;
  logic                        flag_r;
  logic [irt_pkg::CNT_W-1:0]   count_r;

  logic                        in_acc;
  logic                        rd_en;
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  irt_pkg::entry_t             mem_wdata;
  irt_pkg::entry_t             rd_data;
  irt_pkg::scan_res_t          scan;
  logic [AW-1:0]               hit_idx;
  logic [AW-1:0]               free_idx;
  irt_pkg::entry_t             hit_ent;
  logic                        exec_go;

  // Update-cycle results
  logic                        x_we;
  irt_pkg::entry_t             x_wdata;
  logic [AW-1:0]               x_slot;
  logic [1:0]                  x_status;
  logic                        x_flag;
  logic [irt_pkg::CNT_W-1:0]   x_count;
  logic [irt_pkg::CNT_W-1:0]   cnt;
  logic                        unl;
  logic [irt_pkg::CNT_W-1:0]   inc_cnt;
  logic [irt_pkg::CNT_W-1:0]   dec_cnt;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign rd_en     = (state_r == S_SCAN) && issue_on_r;
  assign exec_go   = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  irt_ram #(.DEPTH(ENTRIES), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (rd_en),
    .raddr (issue_idx_r),
    .rdata (rd_data)
  );

  irt_match #(.DEPTH(ENTRIES), .AW(AW)) u_match (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc),
    .vld      (cmp_vld_r),
    .idx      (cmp_idx_r),
    .data     (rd_data),
    .key      (key_r),
    .res      (scan),
    .hit_idx  (hit_idx),
    .free_idx (free_idx),
    .hit_ent  (hit_ent)
  );

  // Decide the outcome from the scan result
  always_comb begin
    cnt      = scan.hit ? hit_ent.count : '0;
    unl      = scan.hit ? hit_ent.unlinked : 1'b0;
    x_slot   = scan.hit ? hit_idx : free_idx;
    inc_cnt  = cnt + irt_pkg::CNT_W'(1);
    dec_cnt  = cnt - rel_r;
    x_we     = 1'b0;
    x_wdata  = '{valid: 1'b1, unlinked: unl, count: cnt, key: key_r};
    x_status = irt_pkg::ST_OK;
    x_flag   = 1'b0;
    x_count  = cnt;
    if (op_r == irt_pkg::OP_UNLINK) begin
      if (!scan.hit) begin
        x_flag  = 1'b1;
        x_count = '0;
      end else begin
        x_we             = 1'b1;
        x_wdata.unlinked = 1'b1;
      end
    end else if (!scan.hit && !scan.free_found) begin
      x_status = irt_pkg::ST_FULL;
      x_count  = '0;
    end else if (op_r == irt_pkg::OP_GET_REF && cnt == irt_pkg::COUNT_MAX) begin
      x_status = irt_pkg::ST_OVER;
    end else if (op_r == irt_pkg::OP_RELEASE && rel_r > cnt) begin
      x_status = irt_pkg::ST_UNDER;
    end else begin
      case (op_r)
        irt_pkg::OP_GET: begin
          x_we = !scan.hit;
        end
        irt_pkg::OP_GET_REF: begin
          x_we          = 1'b1;
          x_wdata.count = inc_cnt;
          x_count       = inc_cnt;
        end
        irt_pkg::OP_RELEASE: begin
          x_we          = 1'b1;
          x_wdata.count = dec_cnt;
          x_count       = dec_cnt;
          if (dec_cnt == '0) begin
            x_wdata.valid = 1'b0;
            x_flag        = unl;
          end
        end
        default: begin
          x_we = 1'b0;
        end
      endcase
    end
  end

  // Memory write: clearing pass or update
  always_comb begin
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = issue_idx_r;
      mem_wdata = '{valid: 1'b0, unlinked: 1'b0, count: '0, key: '0};
    end else begin
      mem_we    = exec_go && x_we;
      mem_waddr = x_slot;
      mem_wdata = x_wdata;
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      issue_idx_r <= '0;
      issue_on_r  <= 1'b0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !exec_go) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          if (issue_idx_r == LAST) begin
            state_r <= S_IDLE;
          end else begin
            issue_idx_r <= issue_idx_r + AW'(1);
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            op_r        <= in_operation;
            key_r       <= in_inode_number;
            rel_r       <= in_release_count;
            issue_idx_r <= '0;
            issue_on_r  <= 1'b1;
            cmp_vld_r   <= 1'b0;
            state_r     <= S_SCAN;
          end
        end
        S_SCAN: begin
          cmp_idx_r <= issue_idx_r;
          if (scan.done) begin
            issue_on_r <= 1'b0;
            cmp_vld_r  <= 1'b0;
            state_r    <= S_EXEC;
          end else begin
            cmp_vld_r <= rd_en;
            if (rd_en) begin
              if (issue_idx_r == LAST) begin
                issue_on_r <= 1'b0;
              end else begin
                issue_idx_r <= issue_idx_r + AW'(1);
              end
            end
          end
        end
        S_EXEC: begin
          if (exec_go) begin
            out_valid_r <= 1'b1;
            status_r    <= x_status;
            flag_r      <= x_flag;
            count_r     <= x_count;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_answer_flag = flag_r;
  assign out_count_after = count_r;

  // A new result appears only out of the update cycle
  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EXEC))
    else $error("result loaded outside update cycle");

  // The table is not written while the scan reads it
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !mem_we)
    else $error("table written during scan");

  // An accepted item starts a scan
  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_SCAN))
    else $error("accepted item did not start a scan");

  // A full-table error carries no count and no flag
  a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == irt_pkg::ST_FULL) |-> (count_r == '0 && !flag_r))
    else $error("table-full result carries data");

endmodule
